// File: sv/polyosc_pkg.sv
// shared types and constants of the band-limited oscillator
`default_nettype none
package polyosc_pkg;

  typedef enum logic [1:0] {
    WAVE_SAW      = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_PWM      = 2'd3
  } wave_t;

  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WAVEFORM    = 3'd0,
    REG_PULSE_WIDTH = 3'd1,
    REG_START_PHASE = 3'd2,
    REG_BASE_FREQ   = 3'd3,
    REG_CHIRP_QUAD  = 3'd4,
    REG_CHIRP_CUBIC = 3'd5,
    REG_START_AMP   = 3'd6,
    REG_AMP_SLOPE   = 3'd7
  } cfg_reg_t;

  localparam int          FIELD_INDEX_W = 20;
  localparam int          DIV_STEPS     = 30;
  localparam int          WAVE_W        = 34;
  localparam logic [31:0] HALF_TURN     = 32'h8000_0000;
  localparam logic [31:0] DT_MIN        = 32'h0000_1000;
  localparam logic [31:0] DT_MAX        = 32'h8000_0000;
  localparam logic [16:0] PW_RESET      = 17'd32768;
  localparam logic signed [WAVE_W-1:0] ONE_Q30 = 34'sd1073741824;
  localparam logic [32:0] RECIP_THIRD   = 33'h0_AAAA_AAAB;

endpackage
`default_nettype wire

// File: sv/polyblep_oscillator.sv
// Band-limited saw / square / triangle / pulse oscillator, mixed into a sample stream.
// Channels: slave stream s_* carries one word per sample, tdata = {mix_in, sample_index}
// (index in the low 20 bits, 56 bits with zero padding). Master stream m_* returns one word
// per input word in the same order: tdata = mix_out, tuser = saturated flag.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index picks the register, cfg_data
// holds the value; cfg_ready is always high. Write only while the pipeline is empty.
// Throughput: one word per cycle, no gaps, while the output is not stalled. The pipeline
// depth is set by the 30-step restoring divider that turns the distance to each waveform
// edge into the residual coordinate, plus the phase, frequency and shaping multipliers
// around it.
// Stall: when m_tready is low the result is held in the output register; the pipeline
// keeps moving and taking input until a finished word reaches its last stage, then
// s_tready falls until the output is taken. Nothing is dropped or repeated.
// Reset: rst (synchronous) empties the pipeline, clears m_tvalid and loads the register
// defaults: saw wave, half duty, all other registers zero.
`default_nettype none
module polyblep_oscillator #(
  parameter int INDEX_BITS = 20
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [55:0]                         s_tdata,   // sample_index, mix_in, pad
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [31:0]                              m_tdata,   // mix_out
  output logic                                     m_tuser,   // saturated
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [polyosc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]                         cfg_data
);
  import polyosc_pkg::*;

  localparam int JB   = (INDEX_BITS < FIELD_INDEX_W) ? INDEX_BITS : FIELD_INDEX_W;
  localparam int QW   = 32 + JB;
  localparam int HA   = QW / 2;
  localparam int PLW  = HA + JB;
  localparam int PHW  = QW - HA + JB + 1;
  localparam int ASW  = (QW > 44) ? QW : 44;
  localparam int AW   = ASW - 19;
  localparam int M3W  = QW - 16 + JB;
  localparam int M3S  = M3W - 6;
  localparam int WW   = 56;
  localparam int PW   = AW + 28;
  localparam int SW   = PW - 23;
  localparam int NDIV = DIV_STEPS;

  typedef struct packed {
    logic                     is_tri;
    logic signed [WAVE_W-1:0] base;
    logic [31:0]              dt;
    logic signed [AW-1:0]     amp;
    logic signed [31:0]       mix;
    logic [1:0]               act;
    logic [1:0]               neg;
  } side_t;

  // configuration registers
  wave_t       waveform;
  logic [16:0] pulse_width;
  logic [31:0] start_phase;
  logic [31:0] base_freq;
  logic [31:0] chirp_quad;
  logic [31:0] chirp_cubic;
  logic [23:0] start_amp;
  logic [31:0] amp_slope;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform    <= WAVE_SAW;
      pulse_width <= PW_RESET;
      start_phase <= '0;
      base_freq   <= '0;
      chirp_quad  <= '0;
      chirp_cubic <= '0;
      start_amp   <= '0;
      amp_slope   <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_WAVEFORM:    waveform    <= wave_t'(cfg_data[1:0]);
        REG_PULSE_WIDTH: pulse_width <= cfg_data[16:0];
        REG_START_PHASE: start_phase <= cfg_data;
        REG_BASE_FREQ:   base_freq   <= cfg_data;
        REG_CHIRP_QUAD:  chirp_quad  <= cfg_data;
        REG_CHIRP_CUBIC: chirp_cubic <= cfg_data;
        REG_START_AMP:   start_amp   <= cfg_data[23:0];
        REG_AMP_SLOPE:   amp_slope   <= cfg_data;
        default:         ;
      endcase
    end
  end

  // pipeline control
  logic adv;
  logic v1, v2, v3, v4, v5;
  logic [NDIV:0] dvld;
  logic vy, vsq, vcu, vd3, vres, vtr, vwv, vam;

  assign adv      = !vam || !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      dvld <= '0;
      vy <= 1'b0; vsq <= 1'b0; vcu <= 1'b0; vd3 <= 1'b0;
      vres <= 1'b0; vtr <= 1'b0; vwv <= 1'b0; vam <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      dvld <= {dvld[NDIV-1:0], v5};
      vy <= dvld[NDIV]; vsq <= vy; vcu <= vsq; vd3 <= vcu;
      vres <= vd3; vtr <= vres; vwv <= vtr; vam <= vwv;
    end
  end

  // stage 1: index products
  logic [JB-1:0]   j_in;
  logic [2*JB-1:0] j2_c;
  logic [31:0]     bj_c;
  logic signed [QW:0] qj_f, a_f, asj_f;

  assign j_in  = s_tdata[JB-1:0];
  assign j2_c  = j_in * j_in;
  assign bj_c  = base_freq * 32'(j_in);
  assign qj_f  = $signed(chirp_quad) * $signed({1'b0, j_in});
  assign a_f   = $signed(chirp_cubic) * $signed({1'b0, j_in});
  assign asj_f = $signed(amp_slope) * $signed({1'b0, j_in});

  logic [JB-1:0]      j1;
  logic [2*JB-1:0]    j2s1;
  logic [31:0]        bj1;
  logic signed [QW-1:0] qj1, a1, asj1;
  logic signed [31:0] mix1;

  // stage 2: partial products of the quadratic and cubic phase terms
  logic [PLW-1:0]        pll_c, plh_c, qll_c;
  logic signed [PHW-1:0] phl_c, phh_c, qhh_c;
  logic [QW-1:0]         ma_c;
  logic signed [ASW:0]   asum_c;

  assign pll_c  = a1[HA-1:0] * j2s1[JB-1:0];
  assign plh_c  = a1[HA-1:0] * j2s1[2*JB-1:JB];
  assign phl_c  = $signed(a1[QW-1:HA]) * $signed({1'b0, j2s1[JB-1:0]});
  assign phh_c  = $signed(a1[QW-1:HA]) * $signed({1'b0, j2s1[2*JB-1:JB]});
  assign qll_c  = qj1[HA-1:0] * j1;
  assign qhh_c  = $signed(qj1[QW-1:HA]) * $signed({1'b0, j1});
  assign ma_c   = a1[QW-1] ? QW'(-a1) : QW'(a1);
  assign asum_c = $signed({{(ASW-43){start_amp[23]}}, start_amp, 20'b0})
                + $signed({{(ASW-QW+1){asj1[QW-1]}}, asj1});

  logic [JB-1:0]         j2r;
  logic [31:0]           bj2;
  logic signed [QW-1:0]  qj2;
  logic [PLW-1:0]        pll2, plh2, qll2;
  logic signed [PHW-1:0] phl2, phh2, qhh2;
  logic [QW-17:0]        ma16_2;
  logic                  aneg2;
  logic signed [AW-1:0]  amp2;
  logic signed [31:0]    mix2;

  // stage 3: sum partials
  logic [71:0] c72_c;
  logic [63:0] q64_c;

  assign c72_c = 72'(pll2) + (72'(plh2) << JB)
               + ({{(72-PHW){phl2[PHW-1]}}, phl2} << HA)
               + ({{(72-PHW){phh2[PHW-1]}}, phh2} << (HA + JB));
  assign q64_c = 64'(qll2) + ({{(64-PHW){qhh2[PHW-1]}}, qhh2} << HA);

  logic [63:0]           cubic3;
  logic [51:0]           quad3;
  logic [31:0]           bj3;
  logic signed [QW-4:0]  qf3;
  logic [M3W-1:0]        m3p3;
  logic                  aneg3;
  logic signed [AW-1:0]  amp3;
  logic signed [31:0]    mix3;

  // stage 4: phase and frequency
  logic [63:0]          ph_c;
  logic [M3W+1:0]       m3x_c;
  logic [M3S-1:0]       m3_c;
  logic signed [WW-1:0] m3s_c, w_c;

  assign ph_c  = {start_phase, 32'b0} + {bj3, 32'b0} + {quad3, 12'b0} + cubic3;
  assign m3x_c = {1'b0, m3p3, 1'b0} + {2'b0, m3p3};
  assign m3_c  = m3x_c[M3W+1:8];
  assign m3s_c = aneg3 ? -$signed({{(WW-M3S){1'b0}}, m3_c})
                       : $signed({{(WW-M3S){1'b0}}, m3_c});
  assign w_c   = $signed({{(WW-48){base_freq[31]}}, base_freq, 16'b0})
               + $signed({{(WW-QW+3){qf3[QW-4]}}, qf3}) + m3s_c;

  logic [31:0]          t4;
  logic signed [WW-1:0] w4;
  logic signed [AW-1:0] amp4;
  logic signed [31:0]   mix4;

  // stage 5: clamp frequency
  logic [WW-1:0] aw_c;
  logic [31:0]   dt_c;

  assign aw_c = w4[WW-1] ? WW'(-w4) : WW'(w4);
  always_comb begin
    if (aw_c < (WW'(1) << 28))      dt_c = DT_MIN;
    else if (aw_c > (WW'(1) << 47)) dt_c = DT_MAX;
    else                            dt_c = aw_c[47:16];
  end

  logic [31:0]          t5, dt5;
  logic signed [AW-1:0] amp5;
  logic signed [31:0]   mix5;

  // stage 6: edge placement and naive wave
  logic [31:0]              w32_c;
  logic                     degen_c;
  logic [31:0]              x_c [2];
  logic [1:0]               lft_c, rgt_c;
  logic [31:0]              num_c [2];
  logic signed [WAVE_W-1:0] half_c, dabs_c, base_c;
  side_t                    side_c;

  assign w32_c   = {pulse_width[15:0], 16'b0};
  assign degen_c = (pulse_width == '0) || pulse_width[16];
  assign x_c[0]  = t5;
  assign x_c[1]  = (waveform == WAVE_PWM) ? t5 - w32_c : t5 + HALF_TURN;
  assign half_c  = $signed({3'b0, t5[31:1]});
  assign dabs_c  = (half_c < ONE_Q30) ? ONE_Q30 - half_c : half_c - ONE_Q30;

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      lft_c[e] = x_c[e] < dt5;
      rgt_c[e] = !lft_c[e] && (({1'b0, x_c[e]} + {1'b0, dt5}) > 33'h1_0000_0000);
      num_c[e] = lft_c[e] ? x_c[e] : -x_c[e];
    end
  end

  always_comb begin
    side_c        = '0;
    side_c.dt     = dt5;
    side_c.amp    = amp5;
    side_c.mix    = mix5;
    side_c.is_tri = (waveform == WAVE_TRIANGLE);
    case (waveform)
      WAVE_SAW: begin
        side_c.base = ONE_Q30 - half_c;
        side_c.act  = {1'b0, lft_c[0] | rgt_c[0]};
        side_c.neg  = {1'b0, lft_c[0]};
      end
      WAVE_SQUARE: begin
        side_c.base = t5[31] ? ONE_Q30 : -ONE_Q30;
        side_c.act  = lft_c | rgt_c;
        side_c.neg  = {lft_c[1], !lft_c[0]};
      end
      WAVE_TRIANGLE: begin
        side_c.base = ONE_Q30 - (dabs_c <<< 1);
        side_c.act  = lft_c | rgt_c;
        side_c.neg  = 2'b10;
      end
      WAVE_PWM: begin
        if (pulse_width == '0) begin
          side_c.base = -ONE_Q30;
        end else if (degen_c) begin
          side_c.base = ONE_Q30;
        end else begin
          side_c.base = (t5 < w32_c) ? ONE_Q30 : -ONE_Q30;
          side_c.act  = lft_c | rgt_c;
          side_c.neg  = {!lft_c[1], lft_c[0]};
        end
      end
      default: side_c.base = ONE_Q30;
    endcase
  end

  // divider stages: quotient of edge distance over dt, one bit per stage
  side_t       dside [NDIV+1];
  logic [31:0] drem  [NDIV+1][2];
  logic [29:0] dq    [NDIV+1][2];
  logic [31:0] drem_n [NDIV][2];
  logic [29:0] dq_n   [NDIV][2];

  always_comb begin
    logic [32:0] r2;
    logic        ge;
    for (int k = 0; k < NDIV; k++) begin
      for (int e = 0; e < 2; e++) begin
        r2 = {drem[k][e], 1'b0};
        ge = r2 >= {1'b0, dside[k].dt};
        drem_n[k][e] = ge ? 32'(r2 - {1'b0, dside[k].dt}) : r2[31:0];
        dq_n[k][e]   = {dq[k][e][28:0], ge};
      end
    end
  end

  // residual shaping
  logic [30:0] y_c [2];
  logic [61:0] ysq_c [2];
  logic [61:0] ycu_c [2];
  logic [62:0] y3_c  [2];

  side_t       sy, ssq, scu, sd3;
  logic [30:0] yy  [2];
  logic [30:0] sq2 [2];
  logic [30:0] sq3 [2];
  logic [30:0] cu3 [2];
  logic [30:0] cb3 [2];
  logic [30:0] sq4 [2];
  logic [29:0] c34 [2];

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      y_c[e]   = 31'h4000_0000 - {1'b0, dq[NDIV][e]};
      ysq_c[e] = yy[e] * yy[e];
      ycu_c[e] = sq2[e] * cu3[e];
      y3_c[e]  = {32'b0, cb3[e]} * {30'b0, RECIP_THIRD};
    end
  end

  // edge terms and their sum
  logic signed [32:0] mag_c [2];
  logic signed [32:0] term_c [2];
  logic signed [32:0] res_c;

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      mag_c[e]  = sd3.is_tri ? $signed({3'b0, c34[e]}) : $signed({2'b0, sq4[e]});
      term_c[e] = !sd3.act[e] ? 33'sd0 : (sd3.neg[e] ? -mag_c[e] : mag_c[e]);
    end
    res_c = term_c[0] + term_c[1];
  end

  side_t              sres;
  logic signed [32:0] res6;

  logic signed [65:0]       trp_c;
  logic signed [WAVE_W-1:0] adj_c;

  assign trp_c = $signed({1'b0, sres.dt}) * res6;
  assign adj_c = sres.is_tri ? trp_c[63:30] : {res6[32], res6};

  side_t                    stw;
  logic signed [WAVE_W-1:0] adj7;

  logic signed [WAVE_W-1:0] wave_c;
  assign wave_c = stw.base + adj7;

  logic signed [AW-1:0] amp8;
  logic signed [31:0]   mix8;
  logic signed [27:0]   w6_8;

  logic signed [PW-1:0] prod_c;
  assign prod_c = amp8 * w6_8;

  logic signed [PW-1:0] prod9;
  logic signed [31:0]   mix9;

  always_ff @(posedge clk) begin
    if (adv) begin
      j1   <= j_in;
      j2s1 <= j2_c;
      bj1  <= bj_c;
      qj1  <= qj_f[QW-1:0];
      a1   <= a_f[QW-1:0];
      asj1 <= asj_f[QW-1:0];
      mix1 <= s_tdata[51:20];

      j2r    <= j1;
      bj2    <= bj1;
      qj2    <= qj1;
      pll2   <= pll_c;
      plh2   <= plh_c;
      phl2   <= phl_c;
      phh2   <= phh_c;
      qll2   <= qll_c;
      qhh2   <= qhh_c;
      ma16_2 <= ma_c[QW-1:16];
      aneg2  <= a1[QW-1];
      amp2   <= asum_c[ASW:20];
      mix2   <= mix1;

      cubic3 <= c72_c[71:8];
      quad3  <= q64_c[51:0];
      bj3    <= bj2;
      qf3    <= qj2[QW-1:3];
      m3p3   <= ma16_2 * j2r;
      aneg3  <= aneg2;
      amp3   <= amp2;
      mix3   <= mix2;

      t4   <= ph_c[63:32] + HALF_TURN;
      w4   <= w_c;
      amp4 <= amp3;
      mix4 <= mix3;

      t5   <= t4;
      dt5  <= dt_c;
      amp5 <= amp4;
      mix5 <= mix4;

      dside[0] <= side_c;
      for (int e = 0; e < 2; e++) begin
        drem[0][e] <= num_c[e];
        dq[0][e]   <= '0;
      end
      for (int k = 0; k < NDIV; k++) begin
        dside[k+1] <= dside[k];
        for (int e = 0; e < 2; e++) begin
          drem[k+1][e] <= drem_n[k][e];
          dq[k+1][e]   <= dq_n[k][e];
        end
      end

      sy  <= dside[NDIV];
      ssq <= sy;
      scu <= ssq;
      sd3 <= scu;
      // cube of y lands one stage after the square; sq2 holds y^2 and cu3 holds y
      for (int e = 0; e < 2; e++) begin
        yy[e]  <= y_c[e];
        sq2[e] <= ysq_c[e][60:30];
        sq3[e] <= sq2[e];
        cu3[e] <= yy[e];
        cb3[e] <= ycu_c[e][60:30];
        sq4[e] <= sq3[e];
        c34[e] <= y3_c[e][62:33];
      end

      sres <= sd3;
      res6 <= res_c;

      stw  <= sres;
      adj7 <= adj_c;

      amp8 <= stw.amp;
      mix8 <= stw.mix;
      w6_8 <= wave_c[WAVE_W-1:6];

      prod9 <= prod_c;
      mix9  <= mix8;
    end
  end

  // output register with saturation
  logic signed [SW-1:0] sum_c;
  logic                 hi_c, lo_c;

  assign sum_c = $signed({{(SW-32){mix9[31]}}, mix9})
               + $signed({prod9[PW-1], prod9[PW-1:24]});
  assign hi_c  = sum_c > $signed(SW'(32'sh7FFF_FFFF));
  assign lo_c  = sum_c < $signed({{(SW-32){1'b1}}, 32'h8000_0000});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= vam;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      m_tdata <= hi_c ? 32'h7FFF_FFFF : (lo_c ? 32'h8000_0000 : sum_c[31:0]);
      m_tuser <= hi_c || lo_c;
    end
  end

endmodule
`default_nettype wire
